[hw/rtl/fcsg_pkg.sv]
// Shared types and constants of the filled circle span generator.
package fcsg_pkg;

  localparam int MAX_RADIUS   = 63;
  localparam int DEC_BASE     = 3;
  localparam int DEC_SCALE    = 4;
  localparam int DEC_DIAG     = 10;
  localparam int DEC_STRAIGHT = 6;
  localparam int RESULT_LIMIT = 64;

  localparam int CRD_W = 8;   // x and y offsets, signed
  localparam int DEC_W = 12;  // decision variable, signed
  localparam int PIX_W = 10;  // span coordinates, signed
  localparam int RAD_W = 6;
  localparam int CNT_W = 6;   // point index within one walk

  typedef logic signed [CRD_W-1:0] coord_t;
  typedef logic signed [DEC_W-1:0] dec_t;
  typedef logic signed [PIX_W-1:0] pix_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    dec_t   d;
  } walk_t;

  typedef struct packed {
    pix_t outer_x_start;
    pix_t outer_x_end;
    pix_t outer_row_low;
    pix_t outer_row_high;
    pix_t inner_x_start;
    pix_t inner_x_end;
    pix_t inner_row_low;
    pix_t inner_row_high;
  } spans_t;

endpackage

[hw/rtl/fcsg_step.sv]
// Walk step unit: advances x, updates y and the decision term.
module fcsg_step import fcsg_pkg::*; (
  input  walk_t cur,
  output walk_t nxt,
  output logic  crossed
);

  logic   diag;
  coord_t x_n;
  coord_t y_n;

  always_comb begin
    diag = cur.d > dec_t'(0);
    x_n  = coord_t'(cur.x + coord_t'(1));
    y_n  = diag ? coord_t'(cur.y - coord_t'(1)) : cur.y;
    if (diag) begin
      nxt.d = dec_t'(cur.d + dec_t'(DEC_SCALE) * dec_t'(dec_t'(x_n) - dec_t'(y_n))
                     + dec_t'(DEC_DIAG));
    end else begin
      nxt.d = dec_t'(cur.d + dec_t'(DEC_SCALE) * dec_t'(x_n) + dec_t'(DEC_STRAIGHT));
    end
    nxt.x   = x_n;
    nxt.y   = y_n;
    crossed = y_n < x_n;
  end

endmodule

[hw/rtl/fcsg_point.sv]
// Span formatter: turns one walk point into four horizontal spans.
module fcsg_point import fcsg_pkg::*; (
  input  logic [7:0] cx,
  input  logic [7:0] cy,
  input  coord_t     x,
  input  coord_t     y,
  output spans_t     spans
);

  pix_t cxs, cys, xs, ys;
  pix_t os, oe, is, ie;

  always_comb begin
    cxs = pix_t'({2'b00, cx});
    cys = pix_t'({2'b00, cy});
    xs  = pix_t'(x);
    ys  = pix_t'(y);
    os  = pix_t'(cxs - xs);
    oe  = pix_t'(cxs + xs);
    is  = pix_t'(cxs - ys);
    ie  = pix_t'(cxs + ys);
    // end left of start: empty span
    if (oe < os) oe = os;
    if (ie < is) ie = is;
    spans.outer_x_start  = os;
    spans.outer_x_end    = oe;
    spans.outer_row_low  = pix_t'(cys + ys);
    spans.outer_row_high = pix_t'(cys - ys);
    spans.inner_x_start  = is;
    spans.inner_x_end    = ie;
    spans.inner_row_low  = pix_t'(cys + xs);
    spans.inner_row_high = pix_t'(cys - xs);
  end

endmodule

[hw/rtl/filled_circle_span_generator.sv]
// Filled circle span generator: sequencer, walk registers and output register.
//
// Input channel (in_valid/in_ready) takes one circle request per beat:
// center_x, center_y, radius, color. Output channel (out_valid/out_ready)
// gives one beat per walk point, each holding four spans that fill the disc
// between them; last_point marks the final beat of a circle.
// A circle of radius r gives about 0.71 r + 2 beats, one per cycle while
// out_ready stays high: the walk step unit advances one point per cycle and
// the output register is reloaded as it empties. The first beat enters the
// output register once the walk has started and that register is free.
// in_ready is high only between walks; the next request is accepted as soon
// as the final beat of the previous one sits in the output register. When
// the receiver stalls, the output register holds its beat and the walk
// waits on it. Synchronous reset rst empties the output register and
// returns the sequencer to idle; no request is lost after reset ends.
module filled_circle_span_generator import fcsg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        center_x,
  input  logic [7:0]        center_y,
  input  logic [RAD_W-1:0]  radius,
  input  logic [15:0]       color,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [9:0] outer_x_start,
  output logic signed [9:0] outer_x_end,
  output logic signed [9:0] outer_row_low,
  output logic signed [9:0] outer_row_high,
  output logic signed [9:0] inner_x_start,
  output logic signed [9:0] inner_x_end,
  output logic signed [9:0] inner_row_low,
  output logic signed [9:0] inner_row_high,
  output logic [15:0]       span_color,
  output logic              last_point
);

  typedef enum logic {S_IDLE, S_WALK} state_t;

  state_t             state;
  walk_t              walk;
  logic [CNT_W-1:0]   cnt;
  logic               cur_last;
  logic [7:0]         cx, cy;
  logic [15:0]        col;
  logic [RAD_W-1:0]   r_sat;
  walk_t              walk_next;
  logic               crossed;
  spans_t             spans;
  logic               load;

  fcsg_step u_step (
    .cur     (walk),
    .nxt     (walk_next),
    .crossed (crossed)
  );

  fcsg_point u_point (
    .cx    (cx),
    .cy    (cy),
    .x     (walk.x),
    .y     (walk.y),
    .spans (spans)
  );

  assign in_ready = state == S_IDLE;
  assign load     = (state == S_WALK) && (!out_valid || out_ready);
  assign r_sat    = (radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state  <= S_WALK;
            cx     <= center_x;
            cy     <= center_y;
            col    <= color;
            walk.x <= coord_t'(0);
            walk.y <= coord_t'({2'b00, r_sat});
            walk.d <= dec_t'(dec_t'(DEC_BASE) - dec_t'({r_sat, 1'b0}));
            cnt      <= '0;
            cur_last <= 1'b0;
          end
        end
        S_WALK: begin
          if (load) begin
            if (cur_last) begin
              state <= S_IDLE;
            end else begin
              walk     <= walk_next;
              cnt      <= CNT_W'(cnt + 1'b1);
              cur_last <= crossed || (cnt >= CNT_W'(RESULT_LIMIT - 2));
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      outer_x_start  <= spans.outer_x_start;
      outer_x_end    <= spans.outer_x_end;
      outer_row_low  <= spans.outer_row_low;
      outer_row_high <= spans.outer_row_high;
      inner_x_start  <= spans.inner_x_start;
      inner_x_end    <= spans.inner_x_end;
      inner_row_low  <= spans.inner_row_low;
      inner_row_high <= spans.inner_row_high;
      span_color     <= col;
      last_point     <= cur_last;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && cnt == '0 && !cur_last)
    else $error("walk not started cleanly after request");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> walk.x <= coord_t'(walk.y + coord_t'(2)))
    else $error("walk ran past the crossing point");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    load && cur_last |=> in_ready && out_valid && last_point)
    else $error("final beat did not end the walk");

  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    load && cnt == '0 |=> !last_point)
    else $error("first beat flagged as last");

endmodule
